@@ hdl/smqf_pkg.sv @@
package smqf_pkg;

  localparam int MAX_PATTERN_DEF = 256;
  localparam int MAX_TEXT_DEF    = 65536;
  localparam int TABLE_DEPTH     = 32768;
  localparam int HASH_W          = $clog2(TABLE_DEPTH);
  localparam int GRAM_LEN        = 4;
  localparam int WIN_BYTES       = 6;
  localparam int NUM_VARIANTS    = 13;
  localparam int CNT_W           = 17;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  localparam int WP = 0;
  localparam int WA = 1;
  localparam int WB = 2;
  localparam int WC = 3;
  localparam int WD = 4;
  localparam int WE = 5;

  typedef struct packed {
    logic       opcode;
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] match_count;
    logic [CNT_W-1:0] check_count;
    logic             error_flag;
  } out_item_t;

  typedef logic [WIN_BYTES-1:0][7:0] win_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_BPAT,
    ST_BGRD,
    ST_BGWR,
    ST_SWIN,
    ST_TRD,
    ST_TTBL,
    ST_TUPD,
    ST_ICHK,
    ST_SWCHK,
    ST_SWRD0,
    ST_SWRD1,
    ST_SWDEC,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_PAT_WIN,
    CMD_GRAM_RD,
    CMD_GRAM_WR,
    CMD_WIN,
    CMD_TXT_GRAM,
    CMD_TBL_RD,
    CMD_UPDATE,
    CMD_INNER,
    CMD_SW_CHECK,
    CMD_SW_RD0,
    CMD_SW_RD1,
    CMD_SW_DEC,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic start_build;
    logic start_search;
    logic search_bad;
    logic clr_done;
    logic win_done;
    logic gram_en;
    logic gram_last;
    logic build_more;
    logic win_ok;
    logic tg_done;
    logic do_swap;
    logic inner_ok;
    logic sw_more;
    logic sw_fail;
    logic out_free;
  } status_t;

  function automatic logic [HASH_W-1:0] gram_hash(logic [7:0] a, logic [7:0] b,
                                                  logic [7:0] c, logic [7:0] d);
    logic [HASH_W-1:0] ha, hb, hc, hd;
    ha = HASH_W'(a);
    hb = HASH_W'(b);
    hc = HASH_W'(c);
    hd = HASH_W'(d);
    return (ha << 6) + (hb << 4) + (hc << 2) + hd;
  endfunction

  function automatic logic [HASH_W-1:0] variant_hash(win_t w, logic [3:0] g);
    logic [HASH_W-1:0] h;
    case (g)
      4'd0:  h = gram_hash(w[WA], w[WB], w[WC], w[WD]);
      4'd1:  h = gram_hash(w[WB], w[WA], w[WC], w[WD]);
      4'd2:  h = gram_hash(w[WB], w[WA], w[WD], w[WC]);
      4'd3:  h = gram_hash(w[WA], w[WC], w[WB], w[WD]);
      4'd4:  h = gram_hash(w[WA], w[WB], w[WD], w[WC]);
      4'd5:  h = gram_hash(w[WP], w[WB], w[WC], w[WD]);
      4'd6:  h = gram_hash(w[WP], w[WC], w[WB], w[WD]);
      4'd7:  h = gram_hash(w[WP], w[WB], w[WD], w[WC]);
      4'd8:  h = gram_hash(w[WP], w[WB], w[WC], w[WE]);
      4'd9:  h = gram_hash(w[WP], w[WC], w[WB], w[WE]);
      4'd10: h = gram_hash(w[WA], w[WB], w[WC], w[WE]);
      4'd11: h = gram_hash(w[WB], w[WA], w[WC], w[WE]);
      4'd12: h = gram_hash(w[WA], w[WC], w[WB], w[WE]);
      default: h = gram_hash(w[WA], w[WB], w[WC], w[WD]);
    endcase
    return h;
  endfunction

  function automatic logic variant_en(logic [3:0] g, logic first_pos, logic more);
    logic en;
    case (g)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: en = 1'b1;
      4'd5, 4'd6, 4'd7:             en = !first_pos;
      4'd8, 4'd9:                   en = !first_pos && more;
      4'd10, 4'd11, 4'd12:          en = more;
      default:                      en = 1'b0;
    endcase
    return en;
  endfunction

endpackage

@@ hdl/smqf_ctrl.sv @@
module smqf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  smqf_pkg::status_t status,
  output logic              in_ready,
  output smqf_pkg::cmd_t    cmd
);
  import smqf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && status.start_build) begin
          state_nxt = ST_CLEAR;
        end else if (in_valid && status.start_search) begin
          state_nxt = status.search_bad ? ST_FIN : ST_SWIN;
        end
      end
      ST_CLEAR: if (status.clr_done) state_nxt = ST_BPAT;
      ST_BPAT:  if (status.win_done) state_nxt = ST_BGRD;
      ST_BGRD: begin
        if (status.gram_en) begin
          state_nxt = ST_BGWR;
        end else if (status.gram_last) begin
          state_nxt = status.build_more ? ST_BPAT : ST_IDLE;
        end
      end
      ST_BGWR: begin
        if (status.gram_last) begin
          state_nxt = status.build_more ? ST_BPAT : ST_IDLE;
        end else begin
          state_nxt = ST_BGRD;
        end
      end
      ST_SWIN:  state_nxt = status.win_ok ? ST_TRD : ST_FIN;
      ST_TRD:   if (status.tg_done) state_nxt = ST_TTBL;
      ST_TTBL:  state_nxt = ST_TUPD;
      ST_TUPD:  state_nxt = status.do_swap ? ST_SWCHK : ST_ICHK;
      ST_ICHK:  state_nxt = status.inner_ok ? ST_TRD : ST_SWIN;
      ST_SWCHK: state_nxt = status.sw_more ? ST_SWRD0 : ST_ICHK;
      ST_SWRD0: state_nxt = ST_SWRD1;
      ST_SWRD1: state_nxt = ST_SWDEC;
      ST_SWDEC: state_nxt = status.sw_fail ? ST_ICHK : ST_SWCHK;
      ST_FIN:   if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = CMD_NONE;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd      = in_valid ? CMD_LOAD : CMD_NONE;
      end
      ST_CLEAR: cmd = CMD_CLEAR;
      ST_BPAT:  cmd = CMD_PAT_WIN;
      ST_BGRD:  cmd = CMD_GRAM_RD;
      ST_BGWR:  cmd = CMD_GRAM_WR;
      ST_SWIN:  cmd = CMD_WIN;
      ST_TRD:   cmd = CMD_TXT_GRAM;
      ST_TTBL:  cmd = CMD_TBL_RD;
      ST_TUPD:  cmd = CMD_UPDATE;
      ST_ICHK:  cmd = CMD_INNER;
      ST_SWCHK: cmd = CMD_SW_CHECK;
      ST_SWRD0: cmd = CMD_SW_RD0;
      ST_SWRD1: cmd = CMD_SW_RD1;
      ST_SWDEC: cmd = CMD_SW_DEC;
      ST_FIN:   cmd = status.out_free ? CMD_FINISH : CMD_NONE;
      default:  cmd = CMD_NONE;
    endcase
  end

endmodule

@@ hdl/smqf_datapath.sv @@
module smqf_datapath #(
  parameter int MAX_PATTERN = smqf_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = smqf_pkg::MAX_TEXT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  smqf_pkg::cmd_t      cmd,
  input  smqf_pkg::in_item_t  in_data,
  input  logic                out_ready,
  output smqf_pkg::status_t   status,
  output logic                out_valid,
  output smqf_pkg::out_item_t out_data
);
  import smqf_pkg::*;

  localparam int PW  = $clog2(MAX_PATTERN + 1);
  localparam int PAW = $clog2(MAX_PATTERN);
  localparam int TW  = $clog2(MAX_TEXT);
  localparam int NW  = TW + 1;
  localparam int KW  = ((TW > PW) ? TW : PW) + 2;
  localparam int SW  = PW + 2;
  localparam int TBW = PW + 1;

  logic [7:0] pmem [MAX_PATTERN];
  logic [7:0] tmem [MAX_TEXT];
  logic signed [TBW-1:0] fmem [TABLE_DEPTH];
  logic signed [TBW-1:0] lmem [TABLE_DEPTH];

  logic [PW-1:0] m_r, m_nxt, fill_r, fill_nxt;
  logic over_r, over_nxt, ready_r, ready_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [HASH_W-1:0] clr_r, clr_nxt, hreg_r, hreg_nxt;
  logic [2:0] rd_r, rd_nxt;
  logic [3:0] g_r, g_nxt;
  logic [PW-1:0] bi_r, bi_nxt;
  win_t win_r, win_nxt;
  logic [KW-1:0] j_r, j_nxt, base_r, base_nxt;
  logic head_r, head_nxt;
  logic signed [SW-1:0] f_r, f_nxt, l_r, l_nxt, i_r, i_nxt;
  logic [PW-1:0] s_r, s_nxt, j2_r, j2_nxt;
  logic [7:0] pa_r, pa_nxt, ta_r, ta_nxt;
  logic [CNT_W-1:0] mc_r, mc_nxt, cc_r, cc_nxt;
  logic err_r, err_nxt;
  logic ov_r, ov_nxt;
  out_item_t od_r, od_nxt;

  logic p_we, t_we, f_we, l_we;
  logic [PAW-1:0] p_waddr;
  logic [HASH_W-1:0] waddr, taddr;
  logic signed [TBW-1:0] f_wd, l_wd;
  logic signed [PW:0] pk;
  logic [KW-1:0] tk;
  logic [7:0] pdata_r, tdata_r, pmask, tmask;
  logic pval_r, tval_r;
  logic signed [TBW-1:0] fdat_r, ldat_r;

  logic is_pat, pat_room, over_eff, over_new, more;
  logic [PW-1:0] fill_eff, fill_new;
  logic signed [SW-1:0] first_s, last_s, fn, ln, inew;
  logic jm_le_n, eq1, eq2;
  logic signed [TBW-1:0] m_s;

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= in_data.symbol;
    end
    pdata_r <= pmem[pk[PAW-1:0]];
    pval_r  <= (pk >= 0) && (pk < $signed({1'b0, m_r}));
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[n_r[TW-1:0]] <= in_data.symbol;
    end
    tdata_r <= tmem[tk[TW-1:0]];
    tval_r  <= tk < KW'(n_r);
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[waddr] <= f_wd;
    end
    if (l_we) begin
      lmem[waddr] <= l_wd;
    end
    fdat_r <= fmem[taddr];
    ldat_r <= lmem[taddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r     <= '0;
      fill_r  <= '0;
      over_r  <= 1'b0;
      ready_r <= 1'b0;
      n_r     <= '0;
      clr_r   <= '0;
      rd_r    <= '0;
      g_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      m_r     <= m_nxt;
      fill_r  <= fill_nxt;
      over_r  <= over_nxt;
      ready_r <= ready_nxt;
      n_r     <= n_nxt;
      clr_r   <= clr_nxt;
      rd_r    <= rd_nxt;
      g_r     <= g_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hreg_r <= hreg_nxt;
    bi_r   <= bi_nxt;
    win_r  <= win_nxt;
    j_r    <= j_nxt;
    base_r <= base_nxt;
    head_r <= head_nxt;
    f_r    <= f_nxt;
    l_r    <= l_nxt;
    i_r    <= i_nxt;
    s_r    <= s_nxt;
    j2_r   <= j2_nxt;
    pa_r   <= pa_nxt;
    ta_r   <= ta_nxt;
    mc_r   <= mc_nxt;
    cc_r   <= cc_nxt;
    err_r  <= err_nxt;
    od_r   <= od_nxt;
  end

  assign pmask = pval_r ? pdata_r : 8'd0;
  assign tmask = tval_r ? tdata_r : 8'd0;
  assign m_s   = $signed({1'b0, m_r});

  assign is_pat   = in_data.opcode == OP_PATTERN;
  assign fill_eff = ready_r ? '0 : fill_r;
  assign over_eff = ready_r ? 1'b0 : over_r;
  assign pat_room = fill_eff < PW'(MAX_PATTERN);
  assign fill_new = pat_room ? fill_eff + PW'(1) : fill_eff;
  assign over_new = over_eff || !pat_room;
  assign more     = ((PW+1)'(bi_r) + (PW+1)'(GRAM_LEN)) < (PW+1)'(m_r);

  assign first_s = SW'(fdat_r);
  assign last_s  = SW'(ldat_r);
  assign fn      = (first_s > f_r) ? first_s : f_r;
  assign ln      = (last_s < l_r) ? last_s : l_r;
  assign inew    = i_r - SW'(1);
  assign jm_le_n = (j_r + KW'(m_r)) <= KW'(n_r);
  assign eq1     = pa_r == ta_r;
  assign eq2     = (((PW+1)'(j2_r) + (PW+1)'(1)) < (PW+1)'(m_r)) &&
                   (pa_r == tmask) && (pmask == ta_r);

  always_comb begin
    status.start_build  = is_pat && in_data.last && !over_new &&
                          (fill_new >= PW'(GRAM_LEN));
    status.start_search = !is_pat && in_data.last;
    status.search_bad   = !ready_r || over_r || (m_r < PW'(GRAM_LEN));
    status.clr_done     = &clr_r;
    status.win_done     = rd_r == 3'(WIN_BYTES);
    status.gram_en      = variant_en(g_r, bi_r == '0, more);
    status.gram_last    = g_r == 4'(NUM_VARIANTS - 1);
    status.build_more   = ((PW+1)'(bi_r) + (PW+1)'(GRAM_LEN + 1)) <= (PW+1)'(m_r);
    status.win_ok       = (j_r + KW'(m_r)) <= (KW'(n_r) + KW'(GRAM_LEN));
    status.tg_done      = rd_r == 3'(GRAM_LEN);
    status.do_swap      = !head_r && (fn == '0) && inew[SW-1] && jm_le_n;
    status.inner_ok     = !i_r[SW-1] && (f_r <= l_r);
    status.sw_more      = j2_r < m_r;
    status.sw_fail      = !eq1 && !eq2;
    status.out_free     = !ov_r || out_ready;
  end

  always_comb begin
    m_nxt    = m_r;
    fill_nxt = fill_r;
    over_nxt = over_r;
    ready_nxt = ready_r;
    n_nxt    = n_r;
    clr_nxt  = clr_r;
    hreg_nxt = hreg_r;
    rd_nxt   = rd_r;
    g_nxt    = g_r;
    bi_nxt   = bi_r;
    win_nxt  = win_r;
    j_nxt    = j_r;
    base_nxt = base_r;
    head_nxt = head_r;
    f_nxt    = f_r;
    l_nxt    = l_r;
    i_nxt    = i_r;
    s_nxt    = s_r;
    j2_nxt   = j2_r;
    pa_nxt   = pa_r;
    ta_nxt   = ta_r;
    mc_nxt   = mc_r;
    cc_nxt   = cc_r;
    err_nxt  = err_r;
    od_nxt   = od_r;
    ov_nxt   = ov_r && !out_ready;
    p_we     = 1'b0;
    p_waddr  = fill_eff[PAW-1:0];
    t_we     = 1'b0;
    f_we     = 1'b0;
    l_we     = 1'b0;
    waddr    = hreg_r;
    f_wd     = $signed({1'b0, bi_r});
    l_wd     = $signed({1'b0, bi_r});
    taddr    = hreg_r;
    pk       = '0;
    tk       = '0;

    case (cmd)
      CMD_LOAD: begin
        if (is_pat) begin
          p_we = pat_room;
          over_nxt = over_new;
          bi_nxt = '0;
          if (in_data.last) begin
            ready_nxt = 1'b1;
            m_nxt = fill_new;
            fill_nxt = '0;
          end else begin
            ready_nxt = 1'b0;
            fill_nxt = fill_new;
            m_nxt = ready_r ? '0 : m_r;
          end
        end else begin
          if (n_r < NW'(MAX_TEXT)) begin
            t_we = 1'b1;
            n_nxt = n_r + NW'(1);
          end
          if (in_data.last) begin
            err_nxt = status.search_bad;
            mc_nxt = '0;
            cc_nxt = '0;
            j_nxt = '0;
          end
        end
      end
      CMD_CLEAR: begin
        f_we = 1'b1;
        l_we = 1'b1;
        waddr = clr_r;
        f_wd = m_s;
        l_wd = '1;
        clr_nxt = clr_r + HASH_W'(1);
      end
      CMD_PAT_WIN: begin
        pk = $signed({1'b0, bi_r}) + $signed((PW+1)'(rd_r)) - (PW+1)'(1);
        if (rd_r != '0) begin
          win_nxt[3'(rd_r - 3'd1)] = pmask;
        end
        rd_nxt = (rd_r == 3'(WIN_BYTES)) ? '0 : rd_r + 3'd1;
      end
      CMD_GRAM_RD: begin
        if (status.gram_en) begin
          taddr = variant_hash(win_r, g_r);
          hreg_nxt = taddr;
        end else if (status.gram_last) begin
          g_nxt = '0;
          bi_nxt = bi_r + PW'(1);
        end else begin
          g_nxt = g_r + 4'd1;
        end
      end
      CMD_GRAM_WR: begin
        f_we = fdat_r == m_s;
        l_we = 1'b1;
        if (status.gram_last) begin
          g_nxt = '0;
          bi_nxt = bi_r + PW'(1);
        end else begin
          g_nxt = g_r + 4'd1;
        end
      end
      CMD_WIN: begin
        if (status.win_ok) begin
          base_nxt = j_r + KW'(m_r) - KW'(GRAM_LEN);
          head_nxt = 1'b1;
        end
      end
      CMD_TXT_GRAM: begin
        tk = base_r + KW'(rd_r);
        if (rd_r != '0) begin
          win_nxt[3'(rd_r - 3'd1)] = tmask;
        end
        rd_nxt = (rd_r == 3'(GRAM_LEN)) ? '0 : rd_r + 3'd1;
      end
      CMD_TBL_RD: begin
        taddr = gram_hash(win_r[0], win_r[1], win_r[2], win_r[3]);
      end
      CMD_UPDATE: begin
        if (head_r) begin
          f_nxt = first_s;
          l_nxt = last_s;
          i_nxt = $signed({2'b00, m_r}) - SW'(GRAM_LEN);
          s_nxt = m_r - PW'(GRAM_LEN - 1);
        end else begin
          if ((fn == '0) && !inew[SW-1]) begin
            s_nxt = PW'(i_r);
          end
          f_nxt = fn - SW'(1);
          l_nxt = ln - SW'(1);
          i_nxt = inew;
          if (status.do_swap) begin
            cc_nxt = cc_r + CNT_W'(1);
            j2_nxt = '0;
          end
        end
      end
      CMD_INNER: begin
        if (status.inner_ok) begin
          base_nxt = j_r + KW'($unsigned(i_r));
          head_nxt = 1'b0;
        end else begin
          j_nxt = j_r + KW'(s_r);
        end
      end
      CMD_SW_CHECK: begin
        if (!status.sw_more) begin
          mc_nxt = mc_r + CNT_W'(1);
        end
      end
      CMD_SW_RD0: begin
        pk = $signed({1'b0, j2_r});
        tk = j_r + KW'(j2_r);
      end
      CMD_SW_RD1: begin
        pa_nxt = pmask;
        ta_nxt = tmask;
        pk = $signed({1'b0, j2_r}) + (PW+1)'(1);
        tk = j_r + KW'(j2_r) + KW'(1);
      end
      CMD_SW_DEC: begin
        if (eq1) begin
          j2_nxt = j2_r + PW'(1);
        end else if (eq2) begin
          j2_nxt = j2_r + PW'(2);
        end
      end
      CMD_FINISH: begin
        ov_nxt = 1'b1;
        od_nxt.match_count = mc_r;
        od_nxt.check_count = cc_r;
        od_nxt.error_flag = err_r;
        n_nxt = '0;
      end
      default: begin
        ov_nxt = ov_r && !out_ready;
      end
    endcase
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

@@ hdl/swap_match_qgram_filter_search_core.sv @@
// Swap-matching search core with a 4-gram position filter.
// Input channel (in_valid/in_ready/in_data): one byte per request, opcode
// selects pattern or text; last closes the pattern or the text.
// Pattern and text bytes are taken one per cycle while the core is idle.
// A pattern request with last that yields a usable pattern (4 or more bytes,
// none dropped) starts table preprocessing: a clearing pass over both
// position tables, then a pass over the pattern positions that writes the
// enabled 4-gram variants of each through the single table write port.
// A text request with last starts the search with in_ready low. Each 4-gram
// takes a run of text reads, one table lookup and an update that narrows the
// bounds; each full swap check takes a check, two reads and a decision per
// comparison step, since the pattern and text memories have one read port each.
// One result (out_valid/out_ready/out_data) follows each text request with
// last. It waits in an output register; the core keeps taking input while it
// waits and stalls only if a second result is ready before the first is taken.
// Reset clears the pattern state and the text length; the first search after
// reset reports error_flag until a pattern is loaded.
module swap_match_qgram_filter_search_core #(
  parameter int MAX_PATTERN = smqf_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = smqf_pkg::MAX_TEXT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smqf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output smqf_pkg::out_item_t out_data
);
  import smqf_pkg::*;

  status_t status;
  cmd_t    cmd;

  smqf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  smqf_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_flag |->
      out_data.match_count == '0 && out_data.check_count == '0)
    else $error("error result carries nonzero counts");

  a_match_le_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.match_count <= out_data.check_count)
    else $error("more matches than checked windows");

  a_search_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == OP_TEXT && in_data.last |=> !in_ready)
    else $error("input taken during search");

endmodule
